/* sv/adsr_pkg.sv */
package adsr_pkg;

    localparam int TICK_W    = 24;
    localparam int LEVEL_W   = 16;
    localparam int ELAPSED_W = 16;
    localparam int TIME_W    = 27;
    localparam int PROD_W    = TICK_W + LEVEL_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = TICK_W;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX   = '1;

    localparam logic [TICK_W-1:0]  ATTACK_RST  = '0;
    localparam logic [TICK_W-1:0]  DECAY_RST   = '0;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = '1;
    localparam logic [TICK_W-1:0]  RELEASE_RST = '0;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
    } div_req_t;

endpackage

/* sv/adsr_div.sv */
module adsr_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  adsr_pkg::div_req_t              req,
    output logic                            done,
    output logic [adsr_pkg::LEVEL_W-1:0]    quot
);

    localparam int CNT_W = $clog2(adsr_pkg::LEVEL_W + 1);

    logic [adsr_pkg::TICK_W-1:0]  rem_reg;
    logic [adsr_pkg::LEVEL_W-1:0] quo_reg;
    logic [adsr_pkg::TICK_W-1:0]  div_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [adsr_pkg::TICK_W:0]    trial;
    logic [adsr_pkg::TICK_W:0]    diff;
    logic                         fits;

    always_comb begin
        trial = {rem_reg, quo_reg[adsr_pkg::LEVEL_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(adsr_pkg::LEVEL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend[adsr_pkg::PROD_W-1:adsr_pkg::LEVEL_W];
            quo_reg <= req.dividend[adsr_pkg::LEVEL_W-1:0];
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[adsr_pkg::TICK_W-1:0] : trial[adsr_pkg::TICK_W-1:0];
            quo_reg <= {quo_reg[adsr_pkg::LEVEL_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

/* sv/adsr_envelope_generator_unit.sv */
// Linear ADSR envelope generator.
// Input channel (s_valid/s_ready): one word per update, carrying the key state
// and the ticks elapsed since the previous word. Result channel (m_valid/m_ready):
// one 16-bit level per input word, 65535 = full scale.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 attack, 1 decay, 2 sustain level, 3 release) at the clock edge; write only
// while no word is in flight.
// Path from accept to m_valid: ADV, then FIN directly when idle or holding sustain,
// EVAL and FIN when the phase ends or the level jumps to a fixed value, and EVAL,
// MUL, DSTART, DIV and FIN when the level comes from the divider. The divider is a
// restoring unit that retires one quotient bit per cycle, after the 24x16 product is
// registered. s_ready is high only while no word is being processed. A finished
// level waits in the output register, so a new word is accepted while the receiver
// stalls; the next level then waits for m_ready.
// Reset (aresetn low, synchronous): envelope idle in release phase, level 0,
// registers back to attack 0, decay 0, sustain 65535, release 0.
module adsr_envelope_generator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_key_down,
    input  logic [adsr_pkg::ELAPSED_W-1:0]    s_elapsed,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]      m_level,
    input  logic                              cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int TW = adsr_pkg::TIME_W;
    localparam int KW = adsr_pkg::TICK_W;
    localparam int LW = adsr_pkg::LEVEL_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADV    = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DSTART = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_DECAY   = 2'd1;
    localparam logic [1:0] PH_SUSTAIN = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    logic [KW-1:0]   attack_reg;
    logic [KW-1:0]   decay_reg;
    logic [LW-1:0]   sustain_reg;
    logic [KW-1:0]   release_reg;
    logic [KW:0]     st_reg;
    logic [KW+1:0]   end_reg;

    logic [2:0]      state_reg;
    logic [1:0]      phase_reg;
    logic [TW-1:0]   time_reg;
    logic            idle_reg;
    logic [LW-1:0]   held_reg;
    logic [1:0]      mode_reg;

    logic            key_reg;
    logic [adsr_pkg::ELAPSED_W-1:0] el_reg;
    logic [KW-1:0]   x_reg;
    logic [LW-1:0]   y_reg;
    logic [KW-1:0]   dvs_reg;
    logic [adsr_pkg::PROD_W-1:0] prod_reg;
    logic [LW-1:0]   res_reg;
    logic            m_valid_reg;
    logic [LW-1:0]   m_level_reg;

    logic            restart;
    logic [TW-1:0]   base;
    logic [TW:0]     sum;
    logic [TW-1:0]   t_sat;
    logic            ge_a;
    logic            ge_st;
    logic            gt_st;
    logic            ge_end;
    logic [TW-1:0]   dec_diff;
    logic [TW-1:0]   rel_diff;
    logic [KW-1:0]   dec_into;
    logic [KW-1:0]   rel_remain;
    logic            out_load;

    adsr_pkg::div_req_t        div_req;
    logic                      div_done;
    logic [LW-1:0]             div_quot;

    adsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        div_req.start    = (state_reg == ST_DSTART);
        div_req.dividend = prod_reg;
        div_req.divisor  = dvs_reg;
    end

    always_comb begin
        restart = idle_reg || (phase_reg == PH_RELEASE);
        if (key_reg) begin
            base = restart ? '0 : time_reg;
        end else begin
            base = (phase_reg != PH_RELEASE) ? TW'(st_reg) : time_reg;
        end
        sum   = {1'b0, base} + (TW + 1)'(el_reg);
        t_sat = sum[TW] ? adsr_pkg::TIME_MAX : sum[TW-1:0];

        ge_a     = time_reg >= TW'(attack_reg);
        ge_st    = time_reg >= TW'(st_reg);
        gt_st    = time_reg > TW'(st_reg);
        ge_end   = time_reg >= TW'(end_reg);
        dec_diff = time_reg - TW'(attack_reg);
        rel_diff = TW'(end_reg) - time_reg;
        dec_into   = (time_reg > TW'(attack_reg)) ? dec_diff[KW-1:0] : '0;
        rel_remain = gt_st ? rel_diff[KW-1:0] : release_reg;
    end

    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= adsr_pkg::ATTACK_RST;
            decay_reg   <= adsr_pkg::DECAY_RST;
            sustain_reg <= adsr_pkg::SUSTAIN_RST;
            release_reg <= adsr_pkg::RELEASE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ATTACK:  attack_reg  <= cfg_wdata[KW-1:0];
                REG_DECAY:   decay_reg   <= cfg_wdata[KW-1:0];
                REG_SUSTAIN: sustain_reg <= cfg_wdata[LW-1:0];
                REG_RELEASE: release_reg <= cfg_wdata[KW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        st_reg  <= {1'b0, attack_reg} + {1'b0, decay_reg};
        end_reg <= {2'b0, attack_reg} + {2'b0, decay_reg} + {2'b0, release_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_RELEASE;
            time_reg    <= '0;
            idle_reg    <= 1'b1;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV: begin
                    if (key_reg) begin
                        if (restart) begin
                            phase_reg <= PH_ATTACK;
                            idle_reg  <= 1'b0;
                            held_reg  <= '0;
                        end
                        if (!restart && phase_reg == PH_SUSTAIN) begin
                            state_reg <= ST_FIN;
                        end else begin
                            time_reg  <= t_sat;
                            state_reg <= ST_EVAL;
                        end
                    end else if (idle_reg) begin
                        held_reg  <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        phase_reg <= PH_RELEASE;
                        time_reg  <= t_sat;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    case (phase_reg)
                        PH_ATTACK: begin
                            if (ge_a && ge_st) begin
                                phase_reg <= PH_SUSTAIN;
                                held_reg  <= sustain_reg;
                                state_reg <= ST_FIN;
                            end else if (ge_a) begin
                                phase_reg <= PH_DECAY;
                                held_reg  <= adsr_pkg::FULL_SCALE;
                                state_reg <= ST_FIN;
                            end else begin
                                state_reg <= ST_MUL;
                            end
                        end
                        PH_DECAY: begin
                            if (gt_st || decay_reg == '0) begin
                                phase_reg <= PH_SUSTAIN;
                                held_reg  <= sustain_reg;
                                state_reg <= ST_FIN;
                            end else begin
                                state_reg <= ST_MUL;
                            end
                        end
                        PH_RELEASE: begin
                            if (ge_end || release_reg == '0) begin
                                idle_reg  <= 1'b1;
                                time_reg  <= '0;
                                held_reg  <= '0;
                                state_reg <= ST_FIN;
                            end else begin
                                state_reg <= ST_MUL;
                            end
                        end
                        default: begin
                            state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_MUL: begin
                    state_reg <= ST_DSTART;
                end
                ST_DSTART: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        case (mode_reg)
                            PH_ATTACK: held_reg <= div_quot;
                            PH_DECAY:  held_reg <= adsr_pkg::FULL_SCALE - div_quot;
                            default: begin
                            end
                        endcase
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            key_reg <= s_key_down;
            el_reg  <= s_elapsed;
        end
        if (out_load) begin
            m_level_reg <= res_reg;
        end
        case (state_reg)
            ST_ADV: begin
                if (key_reg) begin
                    res_reg <= held_reg;
                end else begin
                    res_reg <= '0;
                end
            end
            ST_EVAL: begin
                mode_reg <= phase_reg;
                case (phase_reg)
                    PH_ATTACK: begin
                        res_reg <= ge_st ? sustain_reg : adsr_pkg::FULL_SCALE;
                        x_reg   <= time_reg[KW-1:0];
                        y_reg   <= adsr_pkg::FULL_SCALE;
                        dvs_reg <= attack_reg;
                    end
                    PH_DECAY: begin
                        res_reg <= sustain_reg;
                        x_reg   <= dec_into;
                        y_reg   <= adsr_pkg::FULL_SCALE - sustain_reg;
                        dvs_reg <= decay_reg;
                    end
                    PH_RELEASE: begin
                        res_reg <= '0;
                        x_reg   <= rel_remain;
                        y_reg   <= held_reg;
                        dvs_reg <= release_reg;
                    end
                    default: begin
                        res_reg <= held_reg;
                    end
                endcase
            end
            ST_MUL: begin
                prod_reg <= adsr_pkg::PROD_W'(x_reg) * adsr_pkg::PROD_W'(y_reg);
            end
            ST_DIV: begin
                if (mode_reg == PH_DECAY) begin
                    res_reg <= adsr_pkg::FULL_SCALE - div_quot;
                end else begin
                    res_reg <= div_quot;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;

endmodule

/* sv/adsr_checker.sv */
module adsr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [adsr_pkg::LEVEL_W-1:0]      m_level
);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset does not leave block ready and empty");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result shown one cycle after accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level))
        else $error("stalled result word dropped or changed");

endmodule

bind adsr_envelope_generator_unit adsr_checker u_adsr_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_level    (m_level)
);

/* dv/env_tb_pkg.sv */
`timescale 1ns / 100ps

package env_tb_pkg;

    typedef enum logic [adsr_pkg::CFG_IDX_W-1:0] {
        REG_ATTACK,
        REG_DECAY,
        REG_SUSTAIN,
        REG_RELEASE
    } env_reg_e;

endpackage

/* dv/envelope_checker.sv */
`timescale 1ns / 100ps

module envelope_checker
    import adsr_pkg::*;
    import env_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_key_down,
    input  logic [ELAPSED_W-1:0] s_elapsed,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [LEVEL_W-1:0]   m_level,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   mismatch_count,
    output int                   levels_pending,
    output int                   levels_checked
);

    typedef enum logic [1:0] {
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE
    } env_phase_e;

    logic [TICK_W-1:0]  attack_len;
    logic [TICK_W-1:0]  decay_len;
    logic [LEVEL_W-1:0] sustain_lvl;
    logic [TICK_W-1:0]  release_len;

    env_phase_e         env_phase;
    logic [TIME_W-1:0]  env_time;
    logic               env_idle;
    logic [LEVEL_W-1:0] env_held;

    logic [LEVEL_W-1:0] expected_levels[$];
    int                 mismatches = 0;
    int                 checked = 0;

    function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] t,
                                                   input logic [ELAPSED_W-1:0] el);
        logic [31:0] sum;
        sum = 32'(t) + 32'(el);
        return (sum > 32'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] envelope_step(input logic key,
                                                         input logic [ELAPSED_W-1:0] el);
        logic [31:0]        st;
        logic [31:0]        into;
        logic [31:0]        remain;
        logic [63:0]        q;
        logic [LEVEL_W-1:0] lvl;
        st = 32'(attack_len) + 32'(decay_len);
        if (key) begin
            if (env_idle || env_phase == PH_RELEASE) begin
                env_phase = PH_ATTACK;
                env_time  = '0;
                env_held  = '0;
                env_idle  = 1'b0;
            end
            if (env_phase == PH_ATTACK) begin
                env_time = time_add(env_time, el);
                if (32'(env_time) >= 32'(attack_len)) begin
                    if (32'(env_time) >= st) begin
                        env_phase = PH_SUSTAIN;
                        env_held  = sustain_lvl;
                    end else begin
                        env_phase = PH_DECAY;
                        env_held  = FULL_SCALE;
                    end
                end else begin
                    q = (64'(env_time) * 64'(FULL_SCALE)) / 64'(attack_len);
                    env_held = q[LEVEL_W-1:0];
                end
            end else if (env_phase == PH_DECAY) begin
                env_time = time_add(env_time, el);
                if (32'(env_time) > st || decay_len == '0) begin
                    env_phase = PH_SUSTAIN;
                    env_held  = sustain_lvl;
                end else begin
                    into = (32'(env_time) > 32'(attack_len)) ?
                           32'(env_time) - 32'(attack_len) : 32'd0;
                    q = (64'(into) * (64'(FULL_SCALE) - 64'(sustain_lvl))) / 64'(decay_len);
                    env_held = FULL_SCALE - q[LEVEL_W-1:0];
                end
            end
            lvl = env_held;
        end else if (env_idle) begin
            env_held = '0;
            lvl = '0;
        end else begin
            if (env_phase != PH_RELEASE) begin
                env_phase = PH_RELEASE;
                env_time  = st[TIME_W-1:0];
            end
            env_time = time_add(env_time, el);
            if (32'(env_time) >= st + 32'(release_len) || release_len == '0) begin
                env_idle = 1'b1;
                env_time = '0;
                env_held = '0;
                lvl = '0;
            end else begin
                into   = (32'(env_time) > st) ? 32'(env_time) - st : 32'd0;
                remain = 32'(release_len) - into;
                q = (64'(env_held) * 64'(remain)) / 64'(release_len);
                lvl = q[LEVEL_W-1:0];
            end
        end
        return lvl;
    endfunction

    always @(posedge aclk) begin
        logic [LEVEL_W-1:0] want;
        if (!aresetn) begin
            attack_len  = ATTACK_RST;
            decay_len   = DECAY_RST;
            sustain_lvl = SUSTAIN_RST;
            release_len = RELEASE_RST;
            env_phase   = PH_RELEASE;
            env_time    = '0;
            env_idle    = 1'b1;
            env_held    = '0;
            expected_levels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ATTACK:  attack_len  = cfg_wdata[TICK_W-1:0];
                    REG_DECAY:   decay_len   = cfg_wdata[TICK_W-1:0];
                    REG_SUSTAIN: sustain_lvl = cfg_wdata[LEVEL_W-1:0];
                    REG_RELEASE: release_len = cfg_wdata[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    $display("%0t: level word with none expected: expected none, got %0d",
                             $time, m_level);
                end else begin
                    want = expected_levels.pop_front();
                    checked++;
                    if (m_level !== want) begin
                        mismatches++;
                        $display("%0t: level mismatch: expected %0d, got %0d",
                                 $time, want, m_level);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_levels.push_back(envelope_step(s_key_down, s_elapsed));
        end
        mismatch_count <= mismatches;
        levels_pending <= expected_levels.size();
        levels_checked <= checked;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import adsr_pkg::*;
    import env_tb_pkg::*;

    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 500000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_key_down = 1'b0;
    logic [ELAPSED_W-1:0] s_elapsed = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [LEVEL_W-1:0]   m_level;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic calm = 1'b0;
    int   stall_left = 0;
    int   cycles = 0;
    int   words_sent = 0;
    int   settings = 0;
    int   mismatch_count;
    int   levels_pending;
    int   levels_checked;

    always #4 aclk = ~aclk;

    adsr_envelope_generator_unit u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key_down (s_key_down),
        .s_elapsed  (s_elapsed),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_level    (m_level),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    envelope_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_down     (s_key_down),
        .s_elapsed      (s_elapsed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level        (m_level),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .levels_pending (levels_pending),
        .levels_checked (levels_checked)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                stall_left <= gap_len();
        end
    end

    // Returns at the accepting edge with s_valid still high; the caller drives
    // the next word or drops valid in that same step.
    task automatic send_word(input logic key, input logic [ELAPSED_W-1:0] el);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 40) ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_down <= key;
        s_elapsed  <= el;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (levels_pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic put_reg(input env_reg_e idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic write_regs(input logic [TICK_W-1:0] atk, input logic [TICK_W-1:0] dcy,
                              input logic [LEVEL_W-1:0] sus, input logic [TICK_W-1:0] rel);
        put_reg(REG_ATTACK, atk);
        put_reg(REG_DECAY, dcy);
        put_reg(REG_SUSTAIN, {8'($urandom), sus});
        put_reg(REG_RELEASE, rel);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    function automatic logic [TICK_W-1:0] pick_ticks(input int mode);
        case (mode)
            0: return TICK_W'($urandom_range(0, 400));
            1: return $urandom_range(0, 1) ? '0 : TICK_W'($urandom_range(1, 60));
            2: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return TICK_W'($urandom);
                endcase
            end
            3: return TICK_W'($urandom_range(0, 200000));
            default: return TICK_W'($urandom);
        endcase
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_elapsed(input int unsigned el_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 13)
            return ELAPSED_W'(el_max);
        if (r < 18)
            return ELAPSED_W'($urandom);
        return ELAPSED_W'($urandom_range(0, el_max));
    endfunction

    initial begin
        int               mode;
        int               phase_words;
        int               run;
        int unsigned      el_max;
        logic             key;
        logic [LEVEL_W-1:0] sus;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: everything ends at once
        send_word(1'b0, 16'd0);
        send_word(1'b1, 16'd0);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'd0);

        drain();
        write_regs(24'd1000, 24'd2000, 16'd20000, 24'd3000);
        send_word(1'b1, 16'd0);
        send_word(1'b1, 16'd500);
        send_word(1'b1, 16'd499);
        send_word(1'b1, 16'd1);
        send_word(1'b1, 16'd1000);
        send_word(1'b1, 16'd1000);
        send_word(1'b1, 16'd1);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b0, 16'd0);
        send_word(1'b0, 16'd1500);
        send_word(1'b1, 16'd10);
        send_word(1'b0, 16'd100);
        send_word(1'b0, 16'hFFFF);

        drain();
        write_regs('1, '1, 16'd0, '1);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b1, 16'h5555);
        send_word(1'b0, 16'hAAAA);

        // settings changed in the middle of a note
        drain();
        write_regs(24'd100, 24'd100, 16'd30000, 24'd1000);
        send_word(1'b1, 16'd0);
        send_word(1'b1, 16'd150);
        drain();
        write_regs(24'd5000, 24'd100, 16'd12345, 24'd1000);
        send_word(1'b1, 16'd10);
        send_word(1'b1, 16'hFFFF);
        drain();
        write_regs(24'd5000, 24'd100, 16'd0, 24'd1000);
        send_word(1'b1, 16'd5);
        send_word(1'b0, 16'd0);
        drain();
        write_regs(24'd20000, 24'd100, 16'd0, 24'd2000);
        send_word(1'b0, 16'd10);
        send_word(1'b0, 16'hFFFF);

        while (words_sent < RANDOM_WORDS + 30) begin
            drain();
            mode = $urandom_range(0, 4);
            case ($urandom_range(0, 3))
                0: sus = '0;
                1: sus = '1;
                default: sus = LEVEL_W'($urandom);
            endcase
            write_regs(pick_ticks(mode), pick_ticks(mode), sus, pick_ticks(mode));
            calm <= ($urandom_range(0, 3) == 0);
            case (mode)
                0: el_max = 120;
                1: el_max = 50;
                3: el_max = $urandom_range(1000, 65535);
                default: el_max = 65535;
            endcase
            phase_words = $urandom_range(30, 70);
            for (int n = 0; n < phase_words; ) begin
                run = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 10);
                for (int i = 0; i < run; i++) begin
                    key = ($urandom_range(0, 99) < 12) ? 1'($urandom) : 1'b1;
                    send_word(key, pick_elapsed(el_max));
                end
                n += run;
                run = $urandom_range(1, 8);
                for (int i = 0; i < run; i++) begin
                    key = ($urandom_range(0, 99) < 12) ? 1'($urandom) : 1'b0;
                    send_word(key, pick_elapsed(el_max));
                end
                n += run;
                if ($urandom_range(0, 99) < 10)
                    drain();
            end
        end

        drain();
        calm <= 1'b0;
        repeat (30) @(posedge aclk);
        $display("summary: %0d words over %0d register settings, %0d levels compared",
                 words_sent, settings, levels_checked);
        if (mismatch_count == 0 && levels_pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
